/* src/stc_pkg.sv */
// Shared types, constants and the month table for the seconds to calendar converter.
// Depends on nothing; every RTL file imports it.
package stc_pkg;

    localparam int DN_W   = 20;
    localparam int TOD_W  = 17;
    localparam int SECS_W = 32;
    localparam int YEAR_W = 12;

    localparam logic [16:0] DAY_SECONDS = 17'd86400;
    localparam logic [25:0] DAY_RECIP   = 26'd50903316;
    localparam logic [19:0] EPOCH_DAY   = 20'd727869;
    localparam logic [15:0] MIN_RECIP   = 16'd34953;
    localparam logic [5:0]  MIN_SECONDS = 6'd60;
    localparam logic [17:0] ERA_DAYS    = 18'd146097;
    localparam logic [18:0] CENT_RECIP  = 19'd470373;
    localparam logic [20:0] QUAD_RECIP  = 21'd1469873;
    localparam logic [20:0] YEAR_RECIP  = 21'd1470880;
    localparam logic [10:0] C25_RECIP   = 11'd1311;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;
    localparam logic [7:0]  GROUP_DAYS  = 8'd153;
    localparam logic [5:0]  MONTH_PAIR  = 6'd61;
    localparam logic [4:0]  MONTH_COUNT = 5'd12;

    typedef struct packed {
        logic              neg;
        logic [DN_W-1:0]   dn;
        logic [TOD_W-1:0]  tod;
    } t_split;

    typedef struct packed {
        logic       neg;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_hms;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
    } t_date;

    // Days from 1 March to the first day of each month of a March-based year.
    function automatic logic [8:0] month_start(input logic [4:0] mo);
        logic [8:0] days;
        case (mo)
            5'd0:    days = 9'd0;
            5'd1:    days = 9'd31;
            5'd2:    days = 9'd61;
            5'd3:    days = 9'd92;
            5'd4:    days = 9'd122;
            5'd5:    days = 9'd153;
            5'd6:    days = 9'd184;
            5'd7:    days = 9'd214;
            5'd8:    days = 9'd245;
            5'd9:    days = 9'd275;
            5'd10:   days = 9'd306;
            5'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

/* src/seconds_to_calendar_date_time.sv */
// Top level of the seconds to calendar date and time converter.
// Depends on stc_pkg, stc_day_split, stc_time_split and stc_date.
//
// Input channel: i_valid, o_stall and i_timestamp, seconds since 1993-01-01.
// A transfer happens at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid, i_stall and the year, month, day, hour, minute,
// second and out_of_range fields; a transfer happens with o_valid high and
// i_stall low. Every input transfer yields exactly one output transfer.
// The timezone offset register is written by i_cfg_we and i_cfg_wdata; the user
// must write it only while the block is empty, as the block does not enforce it.
// It resets to zero. Throughput is one item per cycle while no stage stalls.
// An input transfer reaches o_valid through the day split, time of day and date
// stages and one output register. Each stage holds its own valid bit, so a
// stalled receiver freezes only the full stages at the tail and bubbles still
// close up. Reset empties every stage. Local times before the epoch give
// out_of_range with all other fields zero.
module seconds_to_calendar_date_time import stc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [17:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [30:0] i_timestamp,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic        o_out_of_range
);

    logic signed [17:0] r_tz_offset;

    t_split          split_data;
    logic            split_valid;
    logic            split_stall;
    t_hms            time_hms;
    logic [DN_W-1:0] time_dn;
    logic            time_valid;
    logic            time_stall;
    t_date           date_date;
    t_hms            date_hms;
    logic            date_valid;
    logic            date_stall;

    logic            r_vld;
    t_date           r_date;
    t_hms            r_hms;
    t_date           n_date;
    t_hms            n_hms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz_offset <= '0;
        end else if (i_cfg_we) begin
            r_tz_offset <= $signed(i_cfg_wdata);
        end
    end

    stc_day_split u_day_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_timestamp (i_timestamp),
        .i_tz_offset (r_tz_offset),
        .o_valid     (split_valid),
        .i_stall     (split_stall),
        .o_data      (split_data)
    );

    stc_time_split u_time_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .o_stall (split_stall),
        .i_data  (split_data),
        .o_valid (time_valid),
        .i_stall (time_stall),
        .o_hms   (time_hms),
        .o_dn    (time_dn)
    );

    stc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (time_valid),
        .o_stall (time_stall),
        .i_dn    (time_dn),
        .i_hms   (time_hms),
        .o_valid (date_valid),
        .i_stall (date_stall),
        .o_date  (date_date),
        .o_hms   (date_hms)
    );

    assign date_stall = r_vld && i_stall;

    always_comb begin
        if (date_hms.neg) begin
            n_date = '0;
            n_hms  = '0;
            n_hms.neg = 1'b1;
        end else begin
            n_date = date_date;
            n_hms  = date_hms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!date_stall) begin
            r_vld <= date_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!date_stall) begin
            r_date <= n_date;
            r_hms  <= n_hms;
        end
    end

    assign o_valid        = r_vld;
    assign o_year         = r_date.year;
    assign o_month        = r_date.month;
    assign o_day_of_month = r_date.day;
    assign o_hour         = r_hms.hour;
    assign o_minute       = r_hms.minute;
    assign o_second       = r_hms.second;
    assign o_out_of_range = r_hms.neg;

endmodule

/* src/stc_day_split.sv */
// Four-stage section: applies the timezone offset and splits local seconds into
// a day number and seconds of the day. Depends on stc_pkg.
module stc_day_split import stc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [30:0]        i_timestamp,
    input  logic signed [17:0] i_tz_offset,
    output logic               o_valid,
    input  logic               i_stall,
    output t_split             o_data
);

    logic [3:0] r_vld;
    logic [3:0] en;

    logic              r1_neg;
    logic [SECS_W-1:0] r1_secs;
    logic              r2_neg;
    logic [SECS_W-1:0] r2_secs;
    logic [15:0]       r2_q;
    logic              r3_neg;
    logic [15:0]       r3_q;
    logic [17:0]       r3_rem;
    t_split            r4_data;

    logic [32:0]       n1_local;
    logic [50:0]       prod2;
    logic [15:0]       n2_q;
    logic [32:0]       prod3;
    logic [31:0]       diff3;
    logic [17:0]       n3_rem;
    logic [17:0]       rem_adj;
    t_split            n4_data;

    always_comb begin
        en[3] = !r_vld[3] || !i_stall;
        for (int k = 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[3];
    assign o_data  = r4_data;

    always_comb begin
        n1_local = {2'b00, i_timestamp} - {{15{i_tz_offset[17]}}, i_tz_offset};
        prod2    = 51'(r1_secs[31:7]) * 51'(DAY_RECIP);
        n2_q     = prod2[50:35];
        prod3    = 33'(r2_q) * 33'(DAY_SECONDS);
        diff3    = r2_secs - prod3[31:0];
        n3_rem   = diff3[17:0];
        n4_data.neg = r3_neg;
        if (r3_rem >= 18'(DAY_SECONDS)) begin
            rem_adj    = r3_rem - 18'(DAY_SECONDS);
            n4_data.dn = 20'(r3_q) + EPOCH_DAY + 20'd1;
        end else begin
            rem_adj    = r3_rem;
            n4_data.dn = 20'(r3_q) + EPOCH_DAY;
        end
        n4_data.tod = rem_adj[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < 4; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_neg  <= n1_local[32];
            r1_secs <= n1_local[31:0];
        end
        if (en[1]) begin
            r2_neg  <= r1_neg;
            r2_secs <= r1_secs;
            r2_q    <= n2_q;
        end
        if (en[2]) begin
            r3_neg <= r2_neg;
            r3_q   <= r2_q;
            r3_rem <= n3_rem;
        end
        if (en[3]) begin
            r4_data <= n4_data;
        end
    end

endmodule

/* src/stc_time_split.sv */
// Three-stage section: turns seconds of the day into hour, minute and second and
// carries the day number along. Depends on stc_pkg.
module stc_time_split import stc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  t_split          i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output t_hms            o_hms,
    output logic [DN_W-1:0] o_dn
);

    logic [2:0] r_vld;
    logic [2:0] en;

    logic             r1_neg;
    logic [DN_W-1:0]  r1_dn;
    logic [TOD_W-1:0] r1_tod;
    logic [10:0]      r1_mt;
    logic             r2_neg;
    logic [DN_W-1:0]  r2_dn;
    logic [10:0]      r2_mt;
    logic [4:0]       r2_hr;
    logic [5:0]       r2_sec;
    t_hms             r3_hms;
    logic [DN_W-1:0]  r3_dn;

    logic [30:0]      prod1;
    logic [10:0]      n1_mt;
    logic [16:0]      secmul;
    logic [16:0]      secdiff;
    logic [24:0]      hrprod;
    logic [10:0]      minmul;
    logic [10:0]      mindiff;
    t_hms             n3_hms;

    always_comb begin
        en[2] = !r_vld[2] || !i_stall;
        for (int k = 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[2];
    assign o_hms   = r3_hms;
    assign o_dn    = r3_dn;

    always_comb begin
        prod1   = 31'(i_data.tod[16:2]) * 31'(MIN_RECIP);
        n1_mt   = prod1[29:19];
        secmul  = 17'(r1_mt) * 17'(MIN_SECONDS);
        secdiff = r1_tod - secmul;
        hrprod  = 25'(r1_mt[10:2]) * 25'(MIN_RECIP);
        minmul  = 11'(r2_hr) * 11'(MIN_SECONDS);
        mindiff = r2_mt - minmul;
        n3_hms.neg    = r2_neg;
        n3_hms.hour   = r2_hr;
        n3_hms.minute = mindiff[5:0];
        n3_hms.second = r2_sec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < 3; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_neg <= i_data.neg;
            r1_dn  <= i_data.dn;
            r1_tod <= i_data.tod;
            r1_mt  <= n1_mt;
        end
        if (en[1]) begin
            r2_neg <= r1_neg;
            r2_dn  <= r1_dn;
            r2_mt  <= r1_mt;
            r2_hr  <= hrprod[23:19];
            r2_sec <= secdiff[5:0];
        end
        if (en[2]) begin
            r3_hms <= n3_hms;
            r3_dn  <= r2_dn;
        end
    end

endmodule

/* src/stc_date.sv */
// Eleven-stage section: converts a March-based day number into Gregorian year,
// month and day, carrying the time of day along. Depends on stc_pkg.
module stc_date import stc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [DN_W-1:0] i_dn,
    input  t_hms            i_hms,
    output logic            o_valid,
    input  logic            i_stall,
    output t_date           o_date,
    output t_hms            o_hms
);

    localparam int STAGES = 11;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] en;

    t_hms              r_hms [STAGES];
    logic [DN_W-1:0]   r_dn  [7];

    logic [DN_W-1:0]   r0_x1;
    logic [DN_W-1:0]   r1_x1;
    logic [4:0]        r1_q2;
    logic [DN_W-1:0]   r2_x2;
    logic [DN_W-1:0]   r3_x2;
    logic [10:0]       r3_q3;
    logic [DN_W-1:0]   r4_x3;
    logic [YEAR_W-1:0] r5_yr;
    logic [YEAR_W-1:0] r6_yr;
    logic [20:0]       r6_y365;
    logic [5:0]        r6_c100;
    logic [3:0]        r6_c400;
    logic [YEAR_W-1:0] r7_yr;
    logic [8:0]        r7_doy;
    logic [YEAR_W-1:0] r8_yr;
    logic [8:0]        r8_doy;
    logic [1:0]        r8_q4;
    logic [7:0]        r8_r;
    logic [YEAR_W-1:0] r9_yr;
    logic [8:0]        r9_doy;
    logic [4:0]        r9_mo;
    t_date             r10_date;

    logic [20:0]       dn1;
    logic [2:0]        q1;
    logic [36:0]       prod1;
    logic [20:0]       xp3;
    logic [41:0]       prod3;
    logic [40:0]       prod5;
    logic [20:0]       p100;
    logic [18:0]       p400;
    logic [20:0]       sum7;
    logic [1:0]        q4;
    logic [8:0]        base8;
    logic [8:0]        rem8;
    logic [8:0]        r2x;
    logic [2:0]        cnt9;
    logic [4:0]        n9_mo;
    logic [9:0]        dsum;
    logic [4:0]        mo2;
    logic [4:0]        mo_adj;
    t_date             n10_date;

    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[STAGES-1];
    assign o_date  = r10_date;
    assign o_hms   = r_hms[STAGES-1];

    always_comb begin
        dn1 = 21'(i_dn) + 21'd1;
        q1  = 3'd0;
        for (int k = 1; k <= 7; k++) begin
            q1 = q1 + 3'(dn1 >= 21'(k * ERA_DAYS));
        end
        prod1 = 37'(r0_x1[19:2]) * 37'(CENT_RECIP);
        xp3   = 21'(r2_x2) + 21'd1;
        prod3 = 42'(xp3) * 42'(QUAD_RECIP);
        prod5 = 41'(r4_x3) * 41'(YEAR_RECIP);
        p100  = 21'(r5_yr[11:2]) * 21'(C25_RECIP);
        p400  = 19'(r5_yr[11:4]) * 19'(C25_RECIP);
        sum7  = 21'(r_dn[6]) - r6_y365 - 21'(r6_yr[11:2]) + 21'(r6_c100) - 21'(r6_c400);
        q4    = 2'(r7_doy >= 9'(GROUP_DAYS)) + 2'(r7_doy >= 9'(2 * GROUP_DAYS))
              + 2'(r7_doy >= 9'(3 * GROUP_DAYS));
        base8 = 9'(q4) * 9'(GROUP_DAYS);
        rem8  = r7_doy - base8;
        r2x   = {r8_r, 1'b0};
        cnt9  = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            cnt9 = cnt9 + 3'(r2x >= 9'(k * MONTH_PAIR));
        end
        n9_mo = 5'(r8_q4) * 5'd5 + 5'(cnt9);
        dsum  = 10'(r9_doy) + 10'd1 - 10'(month_start(r9_mo));
        mo2   = r9_mo + 5'd2;
        n10_date.day = dsum[4:0];
        if (mo2 >= MONTH_COUNT) begin
            mo_adj        = mo2 - MONTH_COUNT + 5'd1;
            n10_date.year = r9_yr + 12'd1;
        end else begin
            mo_adj        = mo2 + 5'd1;
            n10_date.year = r9_yr;
        end
        n10_date.month = mo_adj[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_hms[0] <= i_hms;
            r_dn[0]  <= i_dn;
            r0_x1    <= i_dn - 20'(q1);
        end
        for (int k = 1; k < STAGES; k++) begin
            if (en[k]) r_hms[k] <= r_hms[k-1];
        end
        for (int k = 1; k < 7; k++) begin
            if (en[k]) r_dn[k] <= r_dn[k-1];
        end
        if (en[1]) begin
            r1_x1 <= r0_x1;
            r1_q2 <= prod1[36:32];
        end
        if (en[2]) begin
            r2_x2 <= r1_x1 + 20'(r1_q2);
        end
        if (en[3]) begin
            r3_x2 <= r2_x2;
            r3_q3 <= prod3[41:31];
        end
        if (en[4]) begin
            r4_x3 <= r3_x2 - 20'(r3_q3);
        end
        if (en[5]) begin
            r5_yr <= prod5[40:29];
        end
        if (en[6]) begin
            r6_yr   <= r5_yr;
            r6_y365 <= 21'(r5_yr) * 21'(YEAR_DAYS);
            r6_c100 <= p100[20:15];
            r6_c400 <= p400[18:15];
        end
        if (en[7]) begin
            r7_yr  <= r6_yr;
            r7_doy <= sum7[8:0];
        end
        if (en[8]) begin
            r8_yr  <= r7_yr;
            r8_doy <= r7_doy;
            r8_q4  <= q4;
            r8_r   <= rem8[7:0];
        end
        if (en[9]) begin
            r9_yr  <= r8_yr;
            r9_doy <= r8_doy;
            r9_mo  <= n9_mo;
        end
        if (en[10]) begin
            r10_date <= n10_date;
        end
    end

endmodule

/* tb/sv/seconds_to_calendar_date_time_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for seconds_to_calendar_date_time: directed rows, then random phases.
// Depends only on the converter RTL; expected dates come from a calendar predictor kept here.
module seconds_to_calendar_date_time_test;

    localparam int     DAY_SECS        = 86400;
    localparam int     MARCH_EPOCH_DAY = 727869;
    localparam longint STAMP_MAX       = 64'sh7FFF_FFFF;
    localparam int     IDLE_LIMIT      = 2000;
    localparam int     RANDOM_PHASES   = 6;
    localparam int     ITEMS_PER_PHASE = 160;
    localparam int     DRAIN_CYCLES    = 25;
    localparam int     ROWS            = 24;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        out_of_range;
    } t_cal;

    typedef struct packed {
        logic [17:0] offset;
        logic [30:0] stamp;
        logic        literal;
        t_cal        want;
    } t_row;

    localparam t_cal BEFORE_EPOCH = '{12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 1'b1};
    localparam t_cal PREDICTED    = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [17:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [30:0] i_timestamp = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic        o_out_of_range;

    t_cal        pending_dates[$];
    logic [17:0] offset_raw = '0;
    int          offset_now = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    int          stall_mode = 0;
    int          stall_tick = 0;

    t_row directed_rows [ROWS] = '{
        '{18'd0, 31'd0,        1'b1, '{12'd1993, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0}},
        '{18'd0, 31'd59,       1'b1, '{12'd1993, 4'd1,  5'd1,  5'd0,  6'd0,  6'd59, 1'b0}},
        '{18'd0, 31'd3599,     1'b1, '{12'd1993, 4'd1,  5'd1,  5'd0,  6'd59, 6'd59, 1'b0}},
        '{18'd0, 31'd86399,    1'b1, '{12'd1993, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59, 1'b0}},
        '{18'd0, 31'd86400,    1'b1, '{12'd1993, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0,  1'b0}},
        '{18'd0, 31'd5097600,  1'b1, '{12'd1993, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0}},
        '{18'd0, 31'd31535999, 1'b1, '{12'd1993, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0}},
        '{18'd0, 31'd99705600, 1'b1, '{12'd1996, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  1'b0}},
        '{18'd0, 31'h7FFFFFFF, 1'b0, PREDICTED},
        '{18'd0, 31'h55555555, 1'b0, PREDICTED},
        '{18'd0, 31'h2AAAAAAA, 1'b0, PREDICTED},
        '{18'd86400, 31'd0,     1'b1, BEFORE_EPOCH},
        '{18'd86400, 31'd86399, 1'b1, BEFORE_EPOCH},
        '{18'd86400, 31'd86400, 1'b1, '{12'd1993, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0}},
        '{18'd86400, 31'h7FFFFFFF, 1'b0, PREDICTED},
        '{-18'sd86400, 31'd0,   1'b1, '{12'd1993, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0, 1'b0}},
        '{-18'sd86400, 31'h7FFFFFFF, 1'b0, PREDICTED},
        '{18'h1FFFF, 31'd131070, 1'b1, BEFORE_EPOCH},
        '{18'h1FFFF, 31'd131071, 1'b1, '{12'd1993, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0}},
        '{18'h1FFFF, 31'd131072, 1'b1, '{12'd1993, 4'd1, 5'd1, 5'd0, 6'd0, 6'd1, 1'b0}},
        '{18'h20000, 31'd0,      1'b0, PREDICTED},
        '{18'h20000, 31'h7FFFFFFF, 1'b0, PREDICTED},
        '{18'd1, 31'd0, 1'b1, BEFORE_EPOCH},
        '{18'd1, 31'd1, 1'b1, '{12'd1993, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0}}
    };

    seconds_to_calendar_date_time i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_timestamp    (i_timestamp),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_out_of_range (o_out_of_range)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_cal calendar_of(logic [30:0] stamp, int offset);
        longint local_secs, day_num, doy, yr, mo, dy, tod;
        t_cal   date;
        date = '0;
        local_secs = longint'(stamp) - offset;
        if (local_secs < 0) begin
            date.out_of_range = 1'b1;
            return date;
        end
        tod = local_secs % DAY_SECS;
        day_num = local_secs / DAY_SECS + MARCH_EPOCH_DAY;
        doy = day_num - (day_num + 1) / 146097;
        doy = doy + doy / 36524;
        doy = doy - (doy + 1) / 1461;
        yr = doy / 365;
        doy = day_num - yr * 365 - yr / 4 + yr / 100 - yr / 400;
        mo = (doy / 153) * 5 + (10 * (doy % 153)) / 305;
        dy = 1 + doy - (mo * 306 + 5) / 10;
        mo = mo + 2;
        yr = yr + mo / 12;
        mo = mo % 12 + 1;
        date.year = 12'(yr);
        date.month = 4'(mo);
        date.day = 5'(dy);
        date.hour = 5'(tod / 3600);
        date.minute = 6'((tod / 60) % 60);
        date.second = 6'(tod % 60);
        return date;
    endfunction

    function automatic logic [30:0] pick_stamp(int offset);
        longint t;
        case ($urandom_range(0, 5))
            0: t = longint'($urandom) & STAMP_MAX;
            1: t = longint'(offset) + int'($urandom_range(0, 400)) - 200;
            2: t = longint'($urandom_range(0, 24855)) * DAY_SECS
                   + int'($urandom_range(0, 20)) - 10;
            3: t = STAMP_MAX - int'($urandom_range(0, 200000));
            4: t = longint'($urandom_range(0, 24854)) * DAY_SECS
                   + int'($urandom_range(0, DAY_SECS - 1));
            default: t = int'($urandom_range(0, 200000));
        endcase
        if (t < 0) begin
            t = 0;
        end
        if (t > STAMP_MAX) begin
            t = STAMP_MAX;
        end
        return t[30:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic compare_field(string name, logic [11:0] got, logic [11:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic send_item(logic [30:0] stamp, logic literal, t_cal want);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_timestamp <= stamp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_dates.push_back(literal ? want : calendar_of(stamp, offset_now));
    endtask

    task automatic write_offset(logic [17:0] raw);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= raw;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        offset_raw = raw;
        offset_now = $signed(raw);
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(64, 256);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 2) == 0);
            2: i_stall <= (stall_tick % 7 < 3);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_cal got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            got = '{o_year, o_month, o_day_of_month, o_hour, o_minute, o_second,
                    o_out_of_range};
            if (pending_dates.size() == 0) begin
                report_mismatch("transfer with no pending expectation");
            end else begin
                want = pending_dates.pop_front();
                compare_field("year", got.year, want.year);
                compare_field("month", 12'(got.month), 12'(want.month));
                compare_field("day_of_month", 12'(got.day), 12'(want.day));
                compare_field("hour", 12'(got.hour), 12'(want.hour));
                compare_field("minute", 12'(got.minute), 12'(want.minute));
                compare_field("second", 12'(got.second), 12'(want.second));
                compare_field("out_of_range", 12'(got.out_of_range),
                              12'(want.out_of_range));
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("seconds_to_calendar_date_time_test failed");
            $finish;
        end
    end

    initial begin
        logic [17:0] next_raw;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].offset != offset_raw) begin
                write_offset(directed_rows[r].offset);
            end
            send_item(directed_rows[r].stamp, directed_rows[r].literal, directed_rows[r].want);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: next_raw = '0;
                1: next_raw = 18'd86400;
                2: next_raw = -18'sd86400;
                4: next_raw = 18'($urandom);
                default: next_raw = 18'(int'($urandom_range(0, 172800)) - 86400);
            endcase
            write_offset(next_raw);
            repeat (ITEMS_PER_PHASE) send_item(pick_stamp(offset_now), 1'b0, PREDICTED);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("seconds_to_calendar_date_time_test passed");
        end else begin
            $display("seconds_to_calendar_date_time_test failed");
        end
        $finish;
    end

endmodule
